[hw/rtl/srf_pkg.sv]
`default_nettype none
package srf_pkg;

   localparam int REGISTER_COUNT = 128;
   localparam int IDX_W          = $clog2(REGISTER_COUNT);
   localparam int ADDR_W         = 7;
   localparam int CSR_ADDR_W     = 3;
   localparam int CSR_DATA_W     = 32;

   localparam logic [7:0] CRC_POLY  = 8'h07;
   localparam logic [7:0] READ_FLAG = 8'h80;
   localparam logic [7:0] ADDR_MASK = 8'h7F;
   localparam logic [7:0] REG_LIMIT = 8'(REGISTER_COUNT);

   localparam logic [1:0] FUNC_WRITE        = 2'd0;
   localparam logic [1:0] FUNC_MASKED_WRITE = 2'd1;
   localparam int         FUNC_READ_BIT     = 1;

   localparam logic [1:0] FRAME_LEN_CRC   = 2'd3;
   localparam logic [1:0] FRAME_LEN_PLAIN = 2'd2;

   localparam logic [CSR_ADDR_W-3:0] CSR_IDX_CRC_ENABLE = '0;

   typedef struct packed {
      logic             rd_en;
      logic [IDX_W-1:0] rd_addr;
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [7:0]       wr_data;
   } srf_shadow_req_type;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_i, input logic [7:0] data_i);
      logic [7:0] c;
      logic       top;
      c = crc_i;
      for (int b = 0; b < 8; b++) begin
         top = c[7] ^ data_i[7-b];
         c   = {c[6:0], 1'b0};
         if (top) begin
            c = c ^ CRC_POLY;
         end
      end
      return c;
   endfunction

endpackage
`default_nettype wire

[hw/rtl/srf_ram.sv]
`default_nettype none
module srf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 128
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[hw/rtl/srf_shadow.sv]
`default_nettype none
module srf_shadow import srf_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire srf_shadow_req_type req,
   output logic [7:0]              rd_data
);

   logic [REGISTER_COUNT-1:0] valid_ff;
   logic [REGISTER_COUNT-1:0] valid_in;
   logic                      rd_valid_ff;
   logic                      rd_valid_in;
   logic [7:0]                ram_q;

   srf_ram #(
      .WIDTH(8),
      .DEPTH(REGISTER_COUNT)
   ) u_ram (
      .clock  (clock),
      .wr_en  (req.wr_en),
      .wr_addr(req.wr_addr),
      .wr_data(req.wr_data),
      .rd_en  (req.rd_en),
      .rd_addr(req.rd_addr),
      .rd_data(ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
      rd_valid_in = req.rd_en ? valid_ff[req.rd_addr] : rd_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         rd_valid_ff <= rd_valid_in;
      end
   end

   // entries never written since reset read as zero
   assign rd_data = rd_valid_ff ? ram_q : 8'h00;

endmodule
`default_nettype wire

[hw/rtl/srf_csr.sv]
`default_nettype none
module srf_csr import srf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready,
   output logic                       crc_en
);

   logic crc_en_ff;
   logic crc_en_in;
   logic sel_crc;

   assign csr_pready = 1'b1;
   assign sel_crc    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_CRC_ENABLE);

   always_comb begin
      crc_en_in = crc_en_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_pready && sel_crc) begin
         crc_en_in = csr_pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_en_ff <= 1'b1;
      end else begin
         crc_en_ff <= crc_en_in;
      end
   end

   assign csr_prdata = sel_crc ? {{(CSR_DATA_W-1){1'b0}}, crc_en_ff} : '0;
   assign crc_en     = crc_en_ff;

endmodule
`default_nettype wire

[hw/rtl/spi_register_framer_crc8_cache_top.sv]
`default_nettype none
// the request beat registers the operands and starts the shadow memory read; the result
// is registered and written back once the output register is free, and only then is
// a new request taken, while the previous result may still wait in the output register
// reset: synchronous, clears control state, crc_enable to 1, shadow copy reads as all zero
// right after reset (per-entry valid bits, no clearing pass)
module spi_register_framer_crc8_cache_top import srf_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic [1:0]            req_func,
   input  wire logic [ADDR_W-1:0]     req_reg_address,
   input  wire logic [7:0]            req_bit_mask,
   input  wire logic [7:0]            req_write_value,
   input  wire logic [7:0]            req_received_data,
   input  wire logic [7:0]            req_received_crc,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic [7:0]                 rsp_command_byte,
   output logic [7:0]                 rsp_payload_byte,
   output logic [7:0]                 rsp_check_byte,
   output logic [1:0]                 rsp_frame_length,
   output logic [7:0]                 rsp_read_value,
   output logic                       rsp_crc_error,
   input  wire logic                  csr_psel,
   input  wire logic                  csr_penable,
   input  wire logic                  csr_pwrite,
   input  wire logic [CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic      [CSR_DATA_W-1:0] csr_prdata,
   output logic                       csr_pready
);

   logic               crc_en;
   srf_shadow_req_type shadow_req;
   logic [7:0]         shadow_q;

   logic               busy_ff, busy_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               is_read_ff;
   logic               is_masked_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [7:0]         mask_ff;
   logic [7:0]         wval_ff;
   logic [7:0]         rdata_ff;
   logic [7:0]         rcrc_ff;
   logic [7:0]         crc_cmd_ff;
   logic [7:0]         cmd_in;

   logic [7:0]         cmd_byte_ff, payload_ff, check_ff, read_value_ff;
   logic [1:0]         frame_len_ff;
   logic               crc_error_ff;

   logic               req_beat;
   logic               finish;
   logic               in_range;
   logic [7:0]         cur;
   logic [7:0]         payload;
   logic [7:0]         crc_data;
   logic [7:0]         crc_full;

   srf_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready),
      .crc_en     (crc_en)
   );

   srf_shadow u_shadow (
      .clock  (clock),
      .reset  (reset),
      .req    (shadow_req),
      .rd_data(shadow_q)
   );

   assign req_ready = !busy_ff;
   assign req_beat  = req_valid && req_ready;
   // the busy phase completes once the output register is free
   assign finish    = busy_ff && (!rsp_valid_ff || rsp_ready);

   assign cmd_in = req_func[FUNC_READ_BIT]
                   ? (READ_FLAG | {1'b0, req_reg_address})
                   : {1'b0, req_reg_address};

   always_comb begin
      in_range = ({1'b0, addr_ff} < REG_LIMIT);
      cur      = in_range ? shadow_q : 8'h00;
      if (is_read_ff) begin
         payload = 8'h00;
      end else if (is_masked_ff) begin
         payload = (cur & ~mask_ff) | wval_ff;
      end else begin
         payload = wval_ff;
      end
      crc_data = is_read_ff ? rdata_ff : payload;
      crc_full = crc8_byte(crc_cmd_ff, crc_data);

      shadow_req.rd_en   = req_beat;
      shadow_req.rd_addr = req_reg_address[IDX_W-1:0];
      shadow_req.wr_en   = finish && !is_read_ff && in_range;
      shadow_req.wr_addr = addr_ff[IDX_W-1:0];
      shadow_req.wr_data = payload;

      busy_in = busy_ff;
      if (req_beat) begin
         busy_in = 1'b1;
      end else if (finish) begin
         busy_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_beat) begin
         is_read_ff   <= req_func[FUNC_READ_BIT];
         is_masked_ff <= (req_func == FUNC_MASKED_WRITE);
         addr_ff      <= req_reg_address;
         mask_ff      <= req_bit_mask;
         wval_ff      <= req_write_value;
         rdata_ff     <= req_received_data;
         rcrc_ff      <= req_received_crc;
         crc_cmd_ff   <= crc8_byte(8'h00, cmd_in);
      end
      if (finish) begin
         cmd_byte_ff   <= is_read_ff ? (READ_FLAG | {1'b0, addr_ff}) : ({1'b0, addr_ff} & ADDR_MASK);
         payload_ff    <= payload;
         check_ff      <= (crc_en && !is_read_ff) ? crc_full : 8'h00;
         frame_len_ff  <= crc_en ? FRAME_LEN_CRC : FRAME_LEN_PLAIN;
         read_value_ff <= is_read_ff ? (rdata_ff & mask_ff) : 8'h00;
         crc_error_ff  <= crc_en && is_read_ff && (crc_full != rcrc_ff);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_command_byte = cmd_byte_ff;
   assign rsp_payload_byte = payload_ff;
   assign rsp_check_byte   = check_ff;
   assign rsp_frame_length = frame_len_ff;
   assign rsp_read_value   = read_value_ff;
   assign rsp_crc_error    = crc_error_ff;

endmodule
`default_nettype wire
